// ----- hdl/bmr_pkg.sv -----
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types and constants of the bus message router.
// ----------------------------------------------------------------------------
package bmr_pkg;

    localparam int ADDR_BITS   = 8;
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_BITS    = 3;
    localparam int IFACE_BITS  = 3;
    localparam int FROM_BITS   = 2;
    localparam int PADDR_BITS  = 5;
    localparam int PDATA_BITS  = 32;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [IFACE_BITS-1:0] iface_code_t;

    // interface codes, result encoding
    localparam iface_code_t IF_HOST   = 3'd0;
    localparam iface_code_t IF_TWI    = 3'd1;
    localparam iface_code_t IF_RADIO  = 3'd2;
    localparam iface_code_t IF_SERIAL = 3'd3;
    localparam iface_code_t IF_DROP   = 3'd4;

    // request opcodes
    localparam logic OP_ROUTE = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register indexes
    typedef enum logic [2:0] {
        REG_OWN_UART  = 3'd0,
        REG_OWN_I2C   = 3'd1,
        REG_OWN_RADIO = 3'd2,
        REG_SUB_MASK  = 3'd3,
        REG_DEV_MASK  = 3'd4,
        REG_DEF_IFACE = 3'd5,
        REG_DEF_HOP   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic                  op;
        addr_t                 dest_addr;
        logic [FROM_BITS-1:0]  from_iface;
        logic [IDX_BITS-1:0]   entry_index;
        logic                  entry_valid;
        addr_t                 entry_subnet;
        iface_code_t           entry_iface;
        addr_t                 entry_next_hop;
    } req_t;

    // table write request
    typedef struct packed {
        logic                 en;
        logic [IDX_BITS-1:0]  index;
        logic                 valid;
        addr_t                subnet;
        iface_code_t          iface;
        addr_t                hop;
    } tbl_wr_t;

    // table lookup answer
    typedef struct packed {
        logic         hit;
        iface_code_t  iface;
        addr_t        hop;
    } tbl_hit_t;

endpackage

// ----- hdl/bmr_ifs.sv -----
// ----------------------------------------------------------------------------
// bmr channel interfaces
// Valid/ready channels for route requests and route results.
// ----------------------------------------------------------------------------
interface bmr_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [bmr_pkg::ADDR_BITS-1:0] dest_addr;
    logic [bmr_pkg::FROM_BITS-1:0] from_iface;
    logic [bmr_pkg::IDX_BITS-1:0]  entry_index;
    logic                          entry_valid;
    logic [bmr_pkg::ADDR_BITS-1:0] entry_subnet;
    logic [bmr_pkg::IFACE_BITS-1:0] entry_iface;
    logic [bmr_pkg::ADDR_BITS-1:0] entry_next_hop;

    modport source (
        output valid, op, dest_addr, from_iface, entry_index, entry_valid,
               entry_subnet, entry_iface, entry_next_hop,
        input  ready
    );
    modport sink (
        input  valid, op, dest_addr, from_iface, entry_index, entry_valid,
               entry_subnet, entry_iface, entry_next_hop,
        output ready
    );
endinterface

interface bmr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bmr_pkg::IFACE_BITS-1:0] route_iface;
    logic [bmr_pkg::ADDR_BITS-1:0]  next_hop;
    logic                           from_table;

    modport source (
        output valid, route_iface, next_hop, from_table,
        input  ready
    );
    modport sink (
        input  valid, route_iface, next_hop, from_table,
        output ready
    );
endinterface

// ----- hdl/bmr_route_table.sv -----
// ----------------------------------------------------------------------------
// bmr_route_table
// Routing table slots with parallel subnet compare and first-match select.
// ----------------------------------------------------------------------------
module bmr_route_table #(
    parameter int TABLE_DEPTH = bmr_pkg::TABLE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bmr_pkg::tbl_wr_t  wr,
    input  bmr_pkg::addr_t    key,
    output bmr_pkg::tbl_hit_t hit
);

    logic                  valid_reg  [TABLE_DEPTH];
    bmr_pkg::addr_t        subnet_reg [TABLE_DEPTH];
    bmr_pkg::iface_code_t  iface_reg  [TABLE_DEPTH];
    bmr_pkg::addr_t        hop_reg    [TABLE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr.en)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (32'(wr.index) == i)
                begin
                    valid_reg[i] <= wr.valid;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (32'(wr.index) == i)
                begin
                    subnet_reg[i] <= wr.subnet;
                    iface_reg[i]  <= wr.iface;
                    hop_reg[i]    <= wr.hop;
                end
            end
        end
    end

    // the first invalid slot terminates the table
    always_comb
    begin
        logic alive;
        alive = 1'b1;
        hit   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            alive = alive & valid_reg[i];
            if (alive && !hit.hit && subnet_reg[i] == key)
            begin
                hit.hit   = 1'b1;
                hit.iface = iface_reg[i];
                hit.hop   = hop_reg[i];
            end
        end
    end

endmodule

// ----- hdl/bus_message_router.sv -----
// ----------------------------------------------------------------------------
// bus_message_router
// Next-hop decision: local delivery, direct subnet rules, table, default.
// ----------------------------------------------------------------------------
// Path: a route request passes the input register, then the result register,
// where its result is presented. Throughput: one request per cycle, set by the
// single pass of decision logic between the two registers; a waiting result
// stalls only routes.
// Reset: all table slots invalid, own addresses and masks zero, default
// interface drop; no clearing pass is needed.
module bus_message_router #(
    parameter int TABLE_DEPTH = bmr_pkg::TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bmr_req_if.sink                          route_req,
    bmr_rsp_if.source                        route_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bmr_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [bmr_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [bmr_pkg::PDATA_BITS-1:0]   prdata,
    output logic                             pready
);

    // configuration
    bmr_pkg::addr_t       own_uart_reg;
    bmr_pkg::addr_t       own_i2c_reg;
    bmr_pkg::addr_t       own_radio_reg;
    bmr_pkg::addr_t       sub_mask_reg;
    bmr_pkg::addr_t       dev_mask_reg;
    bmr_pkg::iface_code_t def_iface_reg;
    bmr_pkg::addr_t       def_hop_reg;

    logic                 cfg_wr;
    bmr_pkg::reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = bmr_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_uart_reg  <= '0;
            own_i2c_reg   <= '0;
            own_radio_reg <= '0;
            sub_mask_reg  <= '0;
            dev_mask_reg  <= '0;
            def_iface_reg <= bmr_pkg::IF_DROP;
            def_hop_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                bmr_pkg::REG_OWN_UART:  own_uart_reg  <= pwdata[bmr_pkg::ADDR_BITS-1:0];
                bmr_pkg::REG_OWN_I2C:   own_i2c_reg   <= pwdata[bmr_pkg::ADDR_BITS-1:0];
                bmr_pkg::REG_OWN_RADIO: own_radio_reg <= pwdata[bmr_pkg::ADDR_BITS-1:0];
                bmr_pkg::REG_SUB_MASK:  sub_mask_reg  <= pwdata[bmr_pkg::ADDR_BITS-1:0];
                bmr_pkg::REG_DEV_MASK:  dev_mask_reg  <= pwdata[bmr_pkg::ADDR_BITS-1:0];
                bmr_pkg::REG_DEF_IFACE: def_iface_reg <= pwdata[bmr_pkg::IFACE_BITS-1:0];
                bmr_pkg::REG_DEF_HOP:   def_hop_reg   <= pwdata[bmr_pkg::ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            bmr_pkg::REG_OWN_UART:  prdata = 32'(own_uart_reg);
            bmr_pkg::REG_OWN_I2C:   prdata = 32'(own_i2c_reg);
            bmr_pkg::REG_OWN_RADIO: prdata = 32'(own_radio_reg);
            bmr_pkg::REG_SUB_MASK:  prdata = 32'(sub_mask_reg);
            bmr_pkg::REG_DEV_MASK:  prdata = 32'(dev_mask_reg);
            bmr_pkg::REG_DEF_IFACE: prdata = 32'(def_iface_reg);
            bmr_pkg::REG_DEF_HOP:   prdata = 32'(def_hop_reg);
            default:                prdata = '0;
        endcase
    end

    // input stage
    logic          s1_valid_reg;
    bmr_pkg::req_t s1_req_reg;
    bmr_pkg::req_t req_in;
    logic          s1_adv;
    logic          req_accept;

    // result stage
    logic                 out_valid_reg;
    bmr_pkg::iface_code_t out_iface_reg;
    bmr_pkg::addr_t       out_hop_reg;
    logic                 out_tab_reg;

    assign req_in.op             = route_req.op;
    assign req_in.dest_addr      = route_req.dest_addr;
    assign req_in.from_iface     = route_req.from_iface;
    assign req_in.entry_index    = route_req.entry_index;
    assign req_in.entry_valid    = route_req.entry_valid;
    assign req_in.entry_subnet   = route_req.entry_subnet;
    assign req_in.entry_iface    = route_req.entry_iface;
    assign req_in.entry_next_hop = route_req.entry_next_hop;

    // a table write leaves without a result, so it never waits on the output
    assign s1_adv = s1_valid_reg &&
                    (s1_req_reg.op == bmr_pkg::OP_WRITE || !out_valid_reg || route_rsp.ready);
    assign route_req.ready = !s1_valid_reg || s1_adv;
    assign req_accept      = route_req.valid && route_req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (route_req.ready)
        begin
            s1_valid_reg <= route_req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_req_reg <= req_in;
        end
    end

    // table writes take effect as the request leaves the input stage
    bmr_pkg::tbl_wr_t  tbl_wr;
    bmr_pkg::tbl_hit_t tbl_hit;
    bmr_pkg::addr_t    key;

    assign key           = s1_req_reg.dest_addr & sub_mask_reg;
    assign tbl_wr.en     = s1_adv && s1_req_reg.op == bmr_pkg::OP_WRITE &&
                           32'(s1_req_reg.entry_index) < TABLE_DEPTH;
    assign tbl_wr.index  = s1_req_reg.entry_index;
    assign tbl_wr.valid  = s1_req_reg.entry_valid;
    assign tbl_wr.subnet = s1_req_reg.entry_subnet;
    assign tbl_wr.iface  = s1_req_reg.entry_iface;
    assign tbl_wr.hop    = s1_req_reg.entry_next_hop;

    bmr_route_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .key   (key),
        .hit   (tbl_hit)
    );

    function automatic bmr_pkg::iface_code_t clamp_iface(bmr_pkg::iface_code_t v);
        return (v > bmr_pkg::IF_DROP) ? bmr_pkg::IF_DROP : v;
    endfunction

    // decision
    bmr_pkg::iface_code_t dec_iface;
    bmr_pkg::addr_t       dec_hop;
    logic                 dec_tab;

    always_comb
    begin
        bmr_pkg::addr_t       dest;
        bmr_pkg::iface_code_t from;
        logic                 bcast;
        logic                 is_local;
        logic                 twi_hit;
        logic                 radio_hit;
        logic                 serial_hit;

        dest  = s1_req_reg.dest_addr;
        from  = {1'b0, s1_req_reg.from_iface};
        bcast = ((dest & sub_mask_reg) == (own_radio_reg & sub_mask_reg)) &&
                (|(dest & own_radio_reg & dev_mask_reg));
        if (from != bmr_pkg::IF_HOST)
        begin
            is_local = dest == own_uart_reg || dest == own_i2c_reg || bcast;
        end
        else
        begin
            is_local = dest == own_uart_reg || dest == own_i2c_reg ||
                       dest == own_radio_reg;
        end

        // zero own address disables that interface's direct rule
        twi_hit    = |own_i2c_reg   && key == (own_i2c_reg & sub_mask_reg);
        radio_hit  = |own_radio_reg && key == (own_radio_reg & sub_mask_reg);
        serial_hit = |own_uart_reg  && key == (own_uart_reg & sub_mask_reg);

        dec_iface = clamp_iface(def_iface_reg);
        dec_hop   = def_hop_reg;
        dec_tab   = 1'b1;
        if (is_local)
        begin
            dec_iface = bmr_pkg::IF_HOST;
            dec_hop   = dest;
            dec_tab   = 1'b0;
        end
        else if (twi_hit)
        begin
            dec_iface = (from == bmr_pkg::IF_TWI) ? bmr_pkg::IF_DROP : bmr_pkg::IF_TWI;
            dec_hop   = (from == bmr_pkg::IF_TWI) ? '0 : dest;
            dec_tab   = 1'b0;
        end
        else if (radio_hit)
        begin
            dec_iface = (from == bmr_pkg::IF_RADIO) ? bmr_pkg::IF_DROP : bmr_pkg::IF_RADIO;
            dec_hop   = (from == bmr_pkg::IF_RADIO) ? '0 : dest;
            dec_tab   = 1'b0;
        end
        else if (serial_hit)
        begin
            dec_iface = (from == bmr_pkg::IF_SERIAL) ? bmr_pkg::IF_DROP : bmr_pkg::IF_SERIAL;
            dec_hop   = (from == bmr_pkg::IF_SERIAL) ? '0 : dest;
            dec_tab   = 1'b0;
        end
        else if (tbl_hit.hit)
        begin
            dec_iface = clamp_iface(tbl_hit.iface);
            dec_hop   = tbl_hit.hop;
            dec_tab   = 1'b1;
        end
    end

    logic out_load;
    assign out_load = s1_adv && s1_req_reg.op == bmr_pkg::OP_ROUTE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (route_rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_iface_reg <= dec_iface;
            out_hop_reg   <= dec_hop;
            out_tab_reg   <= dec_tab;
        end
    end

    assign route_rsp.valid       = out_valid_reg;
    assign route_rsp.route_iface = out_iface_reg;
    assign route_rsp.next_hop    = out_hop_reg;
    assign route_rsp.from_table  = out_tab_reg;

endmodule

// ----- bench/tb_bus_message_router.sv -----
// ----------------------------------------------------------------------------
// tb_bus_message_router
// Self-checking bench for the next-hop router. Route and table-write requests
// go in through a valid/ready channel with random gaps; a shadow routing model
// predicts each result, and results are compared in order as they come out.
// Registers are loaded over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_bus_message_router;

    import bmr_pkg::*;

    localparam int          N_PHASES        = 6;
    localparam int          ITEMS_PER_PHASE = 140;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    typedef struct packed {
        iface_code_t iface;
        addr_t       hop;
        logic        tab;
    } hop_res_t;

    typedef struct {
        req_t rq;
        bit   drain;
    } pend_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    bmr_req_if route_req_ch ();
    bmr_rsp_if route_rsp_ch ();

    bus_message_router uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .route_req (route_req_ch),
        .route_rsp (route_rsp_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // shadow copy of the router's registers and table
    addr_t       own_uart;
    addr_t       own_i2c;
    addr_t       own_radio;
    addr_t       sub_mask;
    addr_t       dev_mask;
    iface_code_t def_iface;
    addr_t       def_hop;
    logic        tbl_valid [TABLE_DEPTH];
    addr_t       tbl_sub   [TABLE_DEPTH];
    iface_code_t tbl_iface [TABLE_DEPTH];
    addr_t       tbl_hop   [TABLE_DEPTH];

    pend_t       pending_reqs[$];
    hop_res_t    expected_routes[$];
    addr_t       gen_sub [TABLE_DEPTH];

    logic        req_taken;
    bit          idle_on;
    int unsigned tx_gap;
    int unsigned rx_hold;
    int unsigned cycle_cnt;
    int unsigned n_errors;
    int unsigned n_routes;
    int unsigned n_writes;
    int unsigned n_checked;
    int unsigned n_settings;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_routes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic flag_error(input string what);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR @%0t: %s", $realtime, what);
    endtask

    function automatic iface_code_t iface_clamp(input iface_code_t v);
        return (v > IF_DROP) ? IF_DROP : v;
    endfunction

    // direct-subnet rule of one interface; returns 1 when it decided
    function automatic logic direct_hit(input addr_t own, input iface_code_t ifc,
                                        input addr_t dest, input iface_code_t from,
                                        inout hop_res_t res);
        if (own == '0 || (dest & sub_mask) != (own & sub_mask))
            return 1'b0;
        if (from == ifc)
            res = '{iface: IF_DROP, hop: '0, tab: 1'b0};
        else
            res = '{iface: ifc, hop: dest, tab: 1'b0};
        return 1'b1;
    endfunction

    // applies one request to the shadow state; returns 1 when a result is due
    function automatic logic route_predict(input req_t rq, output hop_res_t res);
        addr_t       d;
        iface_code_t from;
        addr_t       key;
        logic        bcast;
        logic        to_me;
        logic        stop;
        d    = rq.dest_addr;
        from = {1'b0, rq.from_iface};
        res  = '{iface: IF_DROP, hop: '0, tab: 1'b0};
        if (rq.op == OP_WRITE)
        begin
            if (rq.entry_index < TABLE_DEPTH)
            begin
                tbl_valid[rq.entry_index] = rq.entry_valid;
                tbl_sub[rq.entry_index]   = rq.entry_subnet;
                tbl_iface[rq.entry_index] = rq.entry_iface;
                tbl_hop[rq.entry_index]   = rq.entry_next_hop;
            end
            return 1'b0;
        end
        bcast = ((d & sub_mask) == (own_radio & sub_mask)) &&
                ((d & own_radio & dev_mask) != '0);
        if (from != IF_HOST)
            to_me = (d == own_uart) || (d == own_i2c) || bcast;
        else
            to_me = (d == own_uart) || (d == own_i2c) || (d == own_radio);
        if (to_me)
        begin
            res = '{iface: IF_HOST, hop: d, tab: 1'b0};
            return 1'b1;
        end
        if (direct_hit(own_i2c, IF_TWI, d, from, res))
            return 1'b1;
        if (direct_hit(own_radio, IF_RADIO, d, from, res))
            return 1'b1;
        if (direct_hit(own_uart, IF_SERIAL, d, from, res))
            return 1'b1;
        // first invalid slot terminates the sweep
        key  = d & sub_mask;
        stop = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (!stop)
            begin
                if (!tbl_valid[i])
                    stop = 1'b1;
                else if (tbl_sub[i] == key)
                begin
                    res = '{iface: iface_clamp(tbl_iface[i]), hop: tbl_hop[i], tab: 1'b1};
                    return 1'b1;
                end
            end
        end
        res = '{iface: iface_clamp(def_iface), hop: def_hop, tab: 1'b1};
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic addr_t pick_addr();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r == 2)
            return '1;
        return addr_t'($urandom);
    endfunction

    function automatic addr_t pick_mask();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'hF0;
            3: return 8'hC0;
            4: return 8'hE0;
            5: return 8'hFC;
            default: return addr_t'($urandom);
        endcase
    endfunction

    // request source: one request in flight, gap counted after acceptance
    always @(negedge clk)
    begin : req_driver
        pend_t item;
        logic  busy;
        busy = route_req_ch.valid && !req_taken;
        if (rst_n && !busy)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                route_req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_routes.size() != 0))
            begin
                item = pending_reqs.pop_front();
                route_req_ch.op             <= item.rq.op;
                route_req_ch.dest_addr      <= item.rq.dest_addr;
                route_req_ch.from_iface     <= item.rq.from_iface;
                route_req_ch.entry_index    <= item.rq.entry_index;
                route_req_ch.entry_valid    <= item.rq.entry_valid;
                route_req_ch.entry_subnet   <= item.rq.entry_subnet;
                route_req_ch.entry_iface    <= item.rq.entry_iface;
                route_req_ch.entry_next_hop <= item.rq.entry_next_hop;
                route_req_ch.valid          <= 1'b1;
                tx_gap = idle_on ? pick_gap() : 0;
            end
            else
                route_req_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold == 0 && idle_on && $urandom_range(0, 3) == 0)
                rx_hold = pick_gap();
            if (rx_hold > 0)
            begin
                rx_hold--;
                route_rsp_ch.ready <= 1'b0;
            end
            else
                route_rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : bus_monitor
        req_t     rq;
        hop_res_t want;
        hop_res_t got;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= route_req_ch.valid && route_req_ch.ready;
            if (route_req_ch.valid && route_req_ch.ready)
            begin
                rq = '{op:             route_req_ch.op,
                       dest_addr:      route_req_ch.dest_addr,
                       from_iface:     route_req_ch.from_iface,
                       entry_index:    route_req_ch.entry_index,
                       entry_valid:    route_req_ch.entry_valid,
                       entry_subnet:   route_req_ch.entry_subnet,
                       entry_iface:    route_req_ch.entry_iface,
                       entry_next_hop: route_req_ch.entry_next_hop};
                if (rq.op == OP_WRITE)
                    n_writes++;
                else
                    n_routes++;
                if (route_predict(rq, want))
                    expected_routes.push_back(want);
            end
            if (route_rsp_ch.valid && route_rsp_ch.ready)
            begin
                got = '{iface: route_rsp_ch.route_iface, hop: route_rsp_ch.next_hop,
                        tab: route_rsp_ch.from_table};
                if (expected_routes.size() == 0)
                    flag_error($sformatf("unexpected result iface=%0d hop=%02h tab=%0b",
                                         got.iface, got.hop, got.tab));
                else
                begin
                    want = expected_routes.pop_front();
                    n_checked++;
                    if (got.iface !== want.iface || got.hop !== want.hop ||
                        got.tab !== want.tab)
                        flag_error($sformatf(
                            "result %0d: iface exp %0d got %0d, hop exp %02h got %02h, %s",
                            n_checked, want.iface, got.iface, want.hop, got.hop,
                            $sformatf("from_table exp %0b got %0b", want.tab, got.tab)));
                end
            end
        end
    end

    task automatic apb_cycle(input logic wr, input reg_idx_t idx,
                             input logic [PDATA_BITS-1:0] wdata,
                             output logic [PDATA_BITS-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write one register, mirror it, then read it back
    task automatic set_reg(input reg_idx_t idx, input logic [7:0] value);
        logic [PDATA_BITS-1:0] rd;
        logic [PDATA_BITS-1:0] want;
        apb_cycle(1'b1, idx, {24'b0, value}, rd);
        case (idx)
            REG_OWN_UART:  own_uart  = value;
            REG_OWN_I2C:   own_i2c   = value;
            REG_OWN_RADIO: own_radio = value;
            REG_SUB_MASK:  sub_mask  = value;
            REG_DEV_MASK:  dev_mask  = value;
            REG_DEF_IFACE: def_iface = value[2:0];
            REG_DEF_HOP:   def_hop   = value;
            default: ;
        endcase
        want = (idx == REG_DEF_IFACE) ? {29'b0, value[2:0]} : {24'b0, value};
        apb_cycle(1'b0, idx, '0, rd);
        if (rd !== want)
            flag_error($sformatf("readback of %s: exp %08h got %08h",
                                 idx.name(), want, rd));
    endtask

    task automatic set_config(input addr_t u, input addr_t i2, input addr_t rad,
                              input addr_t sm, input addr_t dm, input iface_code_t di,
                              input addr_t dh);
        set_reg(REG_OWN_UART, u);
        set_reg(REG_OWN_I2C, i2);
        set_reg(REG_OWN_RADIO, rad);
        set_reg(REG_SUB_MASK, sm);
        set_reg(REG_DEV_MASK, dm);
        set_reg(REG_DEF_IFACE, 8'(di));
        set_reg(REG_DEF_HOP, dh);
        n_settings++;
    endtask

    task automatic push_route(input addr_t dest, input logic [FROM_BITS-1:0] from,
                              input bit drain = 1'b0);
        pend_t item;
        item.rq            = req_t'({$urandom, $urandom});
        item.rq.op         = OP_ROUTE;
        item.rq.dest_addr  = dest;
        item.rq.from_iface = from;
        item.drain         = drain;
        pending_reqs.push_back(item);
    endtask

    task automatic push_write(input logic [IDX_BITS-1:0] idx, input logic v,
                              input addr_t sub, input iface_code_t ifc, input addr_t hop);
        pend_t item;
        item.rq                = req_t'({$urandom, $urandom});
        item.rq.op             = OP_WRITE;
        item.rq.entry_index    = idx;
        item.rq.entry_valid    = v;
        item.rq.entry_subnet   = sub;
        item.rq.entry_iface    = ifc;
        item.rq.entry_next_hop = hop;
        item.drain             = 1'b0;
        gen_sub[idx]           = sub;
        pending_reqs.push_back(item);
    endtask

    task automatic rand_write(input logic [IDX_BITS-1:0] idx, input logic v);
        addr_t rnd;
        rnd = addr_t'($urandom);
        push_write(idx, v, ($urandom_range(0, 4) != 0) ? (rnd & sub_mask) : rnd,
                   iface_code_t'($urandom_range(0, 7)), addr_t'($urandom));
    endtask

    // checked at the rising edge, where valid and the queues are settled;
    // settle time covers the two-stage pipe even after result-less writes
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || expected_routes.size() != 0 ||
               route_req_ch.valid);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int unsigned n_load;
        int unsigned mode;
        addr_t       d;
        addr_t       rnd;
        addr_t       own;

        clk        = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        route_req_ch.valid          = 1'b0;
        route_req_ch.op             = OP_ROUTE;
        route_req_ch.dest_addr      = '0;
        route_req_ch.from_iface     = '0;
        route_req_ch.entry_index    = '0;
        route_req_ch.entry_valid    = 1'b0;
        route_req_ch.entry_subnet   = '0;
        route_req_ch.entry_iface    = '0;
        route_req_ch.entry_next_hop = '0;
        route_rsp_ch.ready          = 1'b0;
        idle_on    = 1'b1;
        tx_gap     = 0;
        rx_hold    = 0;
        cycle_cnt  = 0;
        n_errors   = 0;
        n_routes   = 0;
        n_writes   = 0;
        n_checked  = 0;
        n_settings = 0;
        own_uart   = '0;
        own_i2c    = '0;
        own_radio  = '0;
        sub_mask   = '0;
        dev_mask   = '0;
        def_iface  = IF_DROP;
        def_hop    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_sub[i]   = '0;
            tbl_iface[i] = '0;
            tbl_hop[i]   = '0;
            gen_sub[i]   = '0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // out of reset: zero addresses match exactly, empty table drops
        push_route(8'h00, 2'd0);
        push_route(8'h00, 2'd2);
        push_route(8'h55, 2'd1);
        wait_idle();

        set_config(8'h31, 8'h12, 8'h25, 8'hF0, 8'h0F, IF_SERIAL, 8'h77);
        push_write(3'd0, 1'b1, 8'h40, IF_TWI, 8'h13);
        push_write(3'd1, 1'b1, 8'h80, 3'd7, 8'h99);
        push_write(3'd2, 1'b1, 8'hF0, IF_RADIO, 8'hFF);
        push_write(3'd3, 1'b0, 8'hA0, IF_HOST, 8'h00);
        push_write(3'd4, 1'b1, 8'hA0, IF_HOST, 8'h5A);    // hidden behind terminator
        push_write(3'd7, 1'b1, 8'h00, IF_DROP, 8'h01);
        push_route(8'h31, 2'd2);                          // own serial address
        push_route(8'h12, 2'd0);
        push_route(8'h25, 2'd0);                          // own radio, exact from local
        push_route(8'h21, 2'd1);                          // radio device broadcast
        push_route(8'h2A, 2'd1);                          // radio subnet, no device bit
        push_route(8'h2A, 2'd2);                          // would bounce back: drop
        push_route(8'h1F, 2'd1);
        push_route(8'h1F, 2'd0);
        push_route(8'h35, 2'd3);
        push_route(8'h3C, 2'd2);
        push_route(8'h45, 2'd3);                          // table slot 0
        push_route(8'h8A, 2'd1);                          // out-of-range iface code
        push_route(8'hF3, 2'd0);
        push_route(8'hA1, 2'd0);                          // past terminator: default
        push_route(8'h21, 2'd0);                          // no broadcast from local

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            idle_on = (ph % 3 != 2);
            case (ph)
                0: set_config(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 3'd7, 8'hFF);
                1: set_config(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, IF_HOST, 8'h00);
                default: set_config(pick_addr(), pick_addr(), pick_addr(), pick_mask(),
                                    pick_mask(), iface_code_t'($urandom_range(0, 7)),
                                    addr_t'($urandom));
            endcase

            // well-formed table image first, then a mix of routes and rewrites
            n_load = $urandom_range(1, TABLE_DEPTH);
            for (int k = 0; k < n_load; k++)
                rand_write(IDX_BITS'(k), 1'b1);
            if (n_load < TABLE_DEPTH && $urandom_range(0, 1) == 1)
                rand_write(IDX_BITS'(n_load), 1'b0);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                    rand_write(IDX_BITS'($urandom_range(0, TABLE_DEPTH - 1)),
                               ($urandom_range(0, 4) != 0));
                else
                begin
                    mode = $urandom_range(0, 9);
                    rnd  = addr_t'($urandom);
                    case (mode)
                        0:
                        begin
                            case ($urandom_range(0, 2))
                                0: d = own_uart;
                                1: d = own_i2c;
                                default: d = own_radio;
                            endcase
                        end
                        1: d = (own_radio & sub_mask) | (rnd & ~sub_mask);
                        2, 3:
                        begin
                            own = ($urandom_range(0, 1) == 1) ? own_i2c : own_uart;
                            d   = (own & sub_mask) | (rnd & ~sub_mask);
                        end
                        4, 5, 6:
                            d = (gen_sub[$urandom_range(0, TABLE_DEPTH - 1)] & sub_mask) |
                                (rnd & ~sub_mask);
                        default: d = rnd;
                    endcase
                    push_route(d, FROM_BITS'($urandom_range(0, 3)),
                               (k == ITEMS_PER_PHASE / 2) || ($urandom_range(0, 39) == 0));
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_routes.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_routes.size()));
        $display("Covered %0d route and %0d table-write requests over %0d register settings;",
                 n_routes, n_writes, n_settings);
        $display("%0d results compared, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
